### hw/rtl/bfdh_pkg.sv
// ----------------------------------------------------------------------------
// Bloom filter package
// Shared types, codes and constants of the double-hashing Bloom filter.
// ----------------------------------------------------------------------------
package bfdh_pkg;

  localparam int MAX_WORDS_DEF = 1024;

  localparam int FUNC_W  = 2;
  localparam int HASH_W  = 64;
  localparam int COUNT_W = 17;
  localparam int WC_W    = 11;
  localparam int HC_W    = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_PROBE  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_SPARE  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_WORDS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBES = 1'b1;

  localparam logic [63:0] GOLDEN    = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_MUL_A = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_MUL_B = 64'hc4ceb9fe1a85ec53;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 17'h1FFFF;

  typedef logic [FUNC_W-1:0]  func_t;
  typedef logic [HASH_W-1:0]  hash_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_RD,
    ST_CHK,
    ST_OUT
  } state_t;

endpackage

### hw/rtl/bfdh_in_if.sv
// ----------------------------------------------------------------------------
// Bloom filter request channel
// Carries one operation code and one primary key hash per request.
// ----------------------------------------------------------------------------
interface bfdh_in_if;
  logic             valid;
  logic             ready;
  bfdh_pkg::func_t  func;
  bfdh_pkg::hash_t  key_hash;

  modport source (output valid, output func, output key_hash, input ready);
  modport sink (input valid, input func, input key_hash, output ready);
endinterface

### hw/rtl/bfdh_out_if.sv
// ----------------------------------------------------------------------------
// Bloom filter result channel
// Carries the probe answer and the running count of set bits.
// ----------------------------------------------------------------------------
interface bfdh_out_if;
  logic             valid;
  logic             ready;
  logic             probe_hit;
  bfdh_pkg::count_t set_count;

  modport source (output valid, output probe_hit, output set_count, input ready);
  modport sink (input valid, input probe_hit, input set_count, output ready);
endinterface

### hw/rtl/bloom_filter_double_hash_unit.sv
// ----------------------------------------------------------------------------
// Bloom filter with double hashing
// Flat bit store with insert, probe and clear, one shared 32x32 multiplier
// for the key mix and a bit-serial remainder unit for the probe positions.
// ----------------------------------------------------------------------------
//  Channel  Direction  Contents
//  in_ch    sink       func, key_hash
//  out_ch   source     probe_hit, set_count
//  cfg_*    write      words in use (index 0), probes per key (index 1)
//
// Insert and probe run the key mix on the multiplier; each probe position then
// uses the bit-serial remainder unit, a read and an update.
// Clear sweeps the store, one word a cycle.
// After reset a clearing pass over every word runs before the first request.
// A finished result waits in the output register; a stalled sink holds the
// block in its final state until the previous result is taken.
// ----------------------------------------------------------------------------
module bloom_filter_double_hash_unit #(
  parameter int MAX_WORDS = bfdh_pkg::MAX_WORDS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  bfdh_in_if.sink                              in_ch,
  bfdh_out_if.source                           out_ch,
  input  logic                                 cfg_we,
  input  logic [bfdh_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bfdh_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import bfdh_pkg::*;

  localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

  logic [63:0] mem [MAX_WORDS];

  state_t            state_r, state_nxt;
  func_t             func_r, func_nxt;
  logic [63:0]       h1_r, h1_nxt;
  logic [63:0]       h2_r, h2_nxt;
  logic [63:0]       v_r, v_nxt;
  logic [63:0]       prod_r, prod_nxt;
  logic [63:0]       mp_r, mp_nxt;
  logic [1:0]        ph_r, ph_nxt;
  logic              mix_r, mix_nxt;
  logic [63:0]       acc_r, acc_nxt;
  logic [57:0]       dq_r, dq_nxt;
  logic [5:0]        cnt_r, cnt_nxt;
  logic [WC_W-1:0]   rem_r, rem_nxt;
  logic [HC_W-1:0]   i_r, i_nxt;
  logic              hit_r, hit_nxt;
  count_t            count_r, count_nxt;
  logic [AW-1:0]     clr_addr_r, clr_addr_nxt;
  logic              clr_item_r, clr_item_nxt;
  logic [WC_W-1:0]   wc_r;
  logic [HC_W-1:0]   hc_r;
  logic              out_valid_r, out_valid_nxt;
  logic              out_hit_r, out_hit_nxt;
  count_t            out_bits_r, out_bits_nxt;
  logic [63:0]       rdata_r;

  logic [WC_W-1:0]   wc_eff;
  logic              in_fire;
  logic              out_free;
  logic              clr_last;
  logic              bit_hit;
  logic              last_probe;
  logic              div_last;
  logic              mul_last;
  logic              skip_work;
  logic [31:0]       op_a, op_b;
  logic [63:0]       kmul;
  logic [63:0]       prod_sum;
  logic [63:0]       mix_out;
  logic [63:0]       h1_pre;
  logic [WC_W:0]     rem_sh;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [63:0]       mem_wd;
  logic [AW-1:0]     rd_addr;

  assign wc_eff   = (32'(wc_r) > MAX_WORDS) ? WC_W'(MAX_WORDS) : wc_r;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign clr_last = (clr_addr_r == AW'(MAX_WORDS - 1));
  assign bit_hit  = rdata_r[acc_r[5:0]];
  assign last_probe = (i_r == hc_r - HC_W'(1));
  assign div_last = (cnt_r == 6'd0);
  assign mul_last = (ph_r == 2'd3);
  assign skip_work = (in_ch.func != FUNC_INSERT && in_ch.func != FUNC_PROBE) ||
                     (wc_eff == '0) || (hc_r == '0);
  assign rd_addr  = AW'(rem_r);

  assign kmul = mix_r ? MIX_MUL_B : MIX_MUL_A;
  always_comb begin
    case (ph_r)
      2'd0: begin
        op_a = v_r[31:0];
        op_b = kmul[31:0];
      end
      2'd1: begin
        op_a = v_r[31:0];
        op_b = kmul[63:32];
      end
      default: begin
        op_a = v_r[63:32];
        op_b = kmul[31:0];
      end
    endcase
  end
  assign prod_sum = (ph_r == 2'd1) ? mp_r : prod_r + {mp_r[31:0], 32'h0};
  assign mix_out  = prod_sum ^ (prod_sum >> 33);
  assign h1_pre   = (in_ch.key_hash ^ GOLDEN) ^ ((in_ch.key_hash ^ GOLDEN) >> 33);
  assign rem_sh   = {rem_r, dq_r[57]};

  assign in_ch.ready      = (state_r == ST_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.probe_hit = out_hit_r;
  assign out_ch.set_count = out_bits_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_last) begin
          state_nxt = clr_item_r ? ST_OUT : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.func == FUNC_CLEAR) begin
            state_nxt = ST_CLEAR;
          end else if (skip_work) begin
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        if (mul_last && mix_r) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_last) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        if (last_probe || (func_r == FUNC_PROBE && !bit_hit)) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    func_nxt      = func_r;
    h1_nxt        = h1_r;
    h2_nxt        = h2_r;
    v_nxt         = v_r;
    prod_nxt      = prod_r;
    mp_nxt        = mp_r;
    ph_nxt        = ph_r;
    mix_nxt       = mix_r;
    acc_nxt       = acc_r;
    dq_nxt        = dq_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    i_nxt         = i_r;
    hit_nxt       = hit_r;
    count_nxt     = count_r;
    clr_addr_nxt  = clr_addr_r;
    clr_item_nxt  = clr_item_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_hit_nxt   = out_hit_r;
    out_bits_nxt  = out_bits_r;
    mem_we        = 1'b0;
    mem_wa        = clr_addr_r;
    mem_wd        = '0;
    case (state_r)
      ST_CLEAR: begin
        mem_we       = 1'b1;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_last) begin
          clr_addr_nxt = '0;
          count_nxt    = '0;
          hit_nxt      = 1'b0;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          func_nxt     = in_ch.func;
          h1_nxt       = in_ch.key_hash;
          v_nxt        = h1_pre;
          ph_nxt       = 2'd0;
          mix_nxt      = 1'b0;
          i_nxt        = '0;
          hit_nxt      = (in_ch.func == FUNC_PROBE);
          clr_item_nxt = (in_ch.func == FUNC_CLEAR);
        end
      end
      ST_MUL: begin
        mp_nxt = 64'(op_a) * 64'(op_b);
        ph_nxt = ph_r + 2'd1;
        if (ph_r != 2'd0) begin
          prod_nxt = prod_sum;
        end
        if (mul_last) begin
          if (mix_r) begin
            h2_nxt  = mix_out | 64'd1;
            acc_nxt = h1_r;
            dq_nxt  = h1_r[63:6];
            cnt_nxt = 6'd57;
            rem_nxt = '0;
          end else begin
            v_nxt   = mix_out;
            mix_nxt = 1'b1;
          end
        end
      end
      ST_DIV: begin
        dq_nxt  = {dq_r[56:0], 1'b0};
        cnt_nxt = cnt_r - 6'd1;
        if (rem_sh >= {1'b0, wc_eff}) begin
          rem_nxt = WC_W'(rem_sh - {1'b0, wc_eff});
        end else begin
          rem_nxt = rem_sh[WC_W-1:0];
        end
      end
      ST_RD: begin
      end
      ST_CHK: begin
        mem_wa = rd_addr;
        mem_wd = rdata_r | (64'd1 << acc_r[5:0]);
        if (func_r == FUNC_INSERT && !bit_hit) begin
          mem_we = 1'b1;
          if (count_r != COUNT_MAX) begin
            count_nxt = count_r + COUNT_W'(1);
          end
        end
        if (func_r == FUNC_PROBE && !bit_hit) begin
          hit_nxt = 1'b0;
        end
        i_nxt   = i_r + HC_W'(1);
        acc_nxt = acc_r + h2_r;
        dq_nxt  = acc_nxt[63:6];
        cnt_nxt = 6'd57;
        rem_nxt = '0;
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = hit_r;
          out_bits_nxt  = count_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      clr_item_r  <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      wc_r        <= WC_W'(1);
      hc_r        <= HC_W'(1);
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      clr_item_r  <= clr_item_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == CFG_WORDS) begin
        wc_r <= cfg_data[WC_W-1:0];
      end
      if (cfg_we && cfg_index == CFG_PROBES) begin
        hc_r <= cfg_data[HC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    h1_r       <= h1_nxt;
    h2_r       <= h2_nxt;
    v_r        <= v_nxt;
    prod_r     <= prod_nxt;
    mp_r       <= mp_nxt;
    ph_r       <= ph_nxt;
    mix_r      <= mix_nxt;
    acc_r      <= acc_nxt;
    dq_r       <= dq_nxt;
    cnt_r      <= cnt_nxt;
    rem_r      <= rem_nxt;
    i_r        <= i_nxt;
    hit_r      <= hit_nxt;
    out_hit_r  <= out_hit_nxt;
    out_bits_r <= out_bits_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_r <= mem[rd_addr];
  end

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !mem_we)
    else $error("store written while idle");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV || state_r == ST_RD) |-> (rem_r < wc_eff))
    else $error("remainder out of range");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(count_r) <= 64 * MAX_WORDS))
    else $error("set bit count exceeds store size");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != ST_IDLE))
    else $error("request accepted without leaving idle");

  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR && clr_last) |=> (count_r == '0))
    else $error("count not cleared after sweep");

endmodule

### sim/tb_bloom_filter_double_hash_unit.sv
// ----------------------------------------------------------------------------
// Bloom filter double-hash unit testbench
// Drives clear, insert, probe and unused-code requests through several filter sizes and
// probe counts, predicts every result with a bit-accurate model of the filter
// store, and checks the probe answer and the set-bit count of each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class bloom_scoreboard;
  logic [63:0]           store_words [bfdh_pkg::MAX_WORDS_DEF];
  bfdh_pkg::count_t      set_total;
  logic [10:0]           word_cnt;
  logic [4:0]            hash_cnt;
  logic                  hit_q [$];
  bfdh_pkg::count_t      total_q [$];
  int                    errors;
  int                    results;
  int                    hits;

  function new();
    foreach (store_words[k]) store_words[k] = '0;
    set_total = '0;
    word_cnt  = 11'd1;
    hash_cnt  = 5'd1;
    errors    = 0;
    results   = 0;
    hits      = 0;
  endfunction

  function void write_reg(logic [bfdh_pkg::CFG_IDX_W-1:0] idx,
                          logic [bfdh_pkg::CFG_DATA_W-1:0] data);
    if (idx == bfdh_pkg::CFG_WORDS) word_cnt = data[10:0];
    else hash_cnt = data[4:0];
  endfunction

  function logic [63:0] mix64(logic [63:0] v);
    v = v ^ (v >> 33);
    v = v * bfdh_pkg::MIX_MUL_A;
    v = v ^ (v >> 33);
    v = v * bfdh_pkg::MIX_MUL_B;
    v = v ^ (v >> 33);
    return v;
  endfunction

  function void note_request(bfdh_pkg::func_t op, bfdh_pkg::hash_t h1);
    logic [63:0] words;
    logic [63:0] nbits;
    logic [63:0] h2;
    logic [63:0] pos;
    logic [63:0] idx64;
    int          w;
    logic        hit;
    hit   = 1'b0;
    words = (word_cnt > bfdh_pkg::MAX_WORDS_DEF) ? 64'(bfdh_pkg::MAX_WORDS_DEF)
                                                 : 64'(word_cnt);
    if (op == bfdh_pkg::FUNC_CLEAR) begin
      foreach (store_words[k]) store_words[k] = '0;
      set_total = '0;
    end else if (op == bfdh_pkg::FUNC_INSERT || op == bfdh_pkg::FUNC_PROBE) begin
      hit = (op == bfdh_pkg::FUNC_PROBE);
      if (words != 0) begin
        nbits = words * 64;
        h2    = mix64(h1 ^ bfdh_pkg::GOLDEN) | 64'd1;
        for (int i = 0; i < hash_cnt; i++) begin
          idx64 = 64'(i);
          pos   = (h1 + idx64 * h2) % nbits;
          w     = int'(pos >> 6);
          if (op == bfdh_pkg::FUNC_INSERT) begin
            if (!store_words[w][pos[5:0]]) begin
              store_words[w][pos[5:0]] = 1'b1;
              if (set_total != bfdh_pkg::COUNT_MAX) set_total++;
            end
          end else if (!store_words[w][pos[5:0]]) begin
            hit = 1'b0;
            break;
          end
        end
      end
    end
    hit_q.push_back(hit);
    total_q.push_back(set_total);
  endfunction

  function void check_result(logic hit, bfdh_pkg::count_t total);
    logic             exp_hit;
    bfdh_pkg::count_t exp_total;
    results++;
    if (hit_q.size() == 0) begin
      $display("%0t: unexpected result probe_hit %0d set_count %0d", $time, hit, total);
      errors++;
      return;
    end
    exp_hit   = hit_q.pop_front();
    exp_total = total_q.pop_front();
    if (hit) hits++;
    if (hit !== exp_hit) begin
      $display("%0t: probe_hit expected %0d actual %0d", $time, exp_hit, hit);
      errors++;
    end
    if (total !== exp_total) begin
      $display("%0t: set_count expected %0d actual %0d", $time, exp_total, total);
      errors++;
    end
  endfunction

  function int pending();
    return hit_q.size();
  endfunction
endclass

module tb_bloom_filter_double_hash_unit;
  import bfdh_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  steady_sink;
  int                    sent;
  hash_t                 key_pool [$];

  bfdh_in_if  in_ch ();
  bfdh_out_if out_ch ();

  bloom_scoreboard filter_sb;

  bloom_filter_double_hash_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  initial begin
    filter_sb = new();
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) filter_sb.check_result(out_ch.probe_hit,
                                                               out_ch.set_count);
      if (in_ch.valid && in_ch.ready) filter_sb.note_request(in_ch.func, in_ch.key_hash);
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      int gap;
      gap = steady_sink ? 0 : $urandom_range(6);
      if (gap > 0) begin
        @(negedge clk);
        out_ch.ready = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ch.ready = 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  task automatic send_request(func_t op, hash_t h1);
    int gap;
    gap = steady_sink ? 0 : $urandom_range(6);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.func     = op;
    in_ch.key_hash = h1;
    in_ch.valid    = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic drain_results();
    in_ch.valid = 1'b0;
    while (filter_sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    filter_sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_filter(logic [10:0] words, logic [10:0] probes);
    drain_results();
    write_reg(CFG_WORDS, words);
    write_reg(CFG_PROBES, probes);
  endtask

  function automatic hash_t rand_key();
    return {$urandom(), $urandom()};
  endfunction

  task automatic random_request();
    int    r;
    hash_t h1;
    r = $urandom_range(99);
    if (r < 2) begin
      send_request(FUNC_CLEAR, rand_key());
    end else if (r < 5) begin
      send_request(FUNC_SPARE, rand_key());
    end else if (r < 50 || key_pool.size() == 0) begin
      h1 = rand_key();
      if (key_pool.size() >= 200) void'(key_pool.pop_front());
      key_pool.push_back(h1);
      send_request(FUNC_INSERT, h1);
    end else if (r < 78) begin
      send_request(FUNC_PROBE, key_pool[$urandom_range(key_pool.size() - 1)]);
    end else begin
      send_request(FUNC_PROBE, rand_key());
    end
  endtask

  task automatic run_phase(logic [10:0] words, logic [10:0] probes, int count);
    set_filter(words, probes);
    steady_sink = ($urandom_range(3) == 0);
    repeat (count) random_request();
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_ch.valid    = 1'b0;
    in_ch.func     = FUNC_CLEAR;
    in_ch.key_hash = '0;
    steady_sink    = 1'b0;
    sent           = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_request(FUNC_PROBE, 64'd0);
    send_request(FUNC_INSERT, 64'd0);
    send_request(FUNC_PROBE, 64'd0);
    send_request(FUNC_SPARE, '1);
    send_request(FUNC_INSERT, '1);
    send_request(FUNC_PROBE, '1);
    send_request(FUNC_PROBE, 64'h8000_0000_0000_0001);
    send_request(FUNC_CLEAR, '1);
    send_request(FUNC_PROBE, '1);
    set_filter(11'd1024, 11'd30);
    send_request(FUNC_INSERT, 64'h0123_4567_89ab_cdef);
    send_request(FUNC_PROBE, 64'h0123_4567_89ab_cdef);
    send_request(FUNC_INSERT, '1);
    send_request(FUNC_PROBE, 64'hfedc_ba98_7654_3210);
    set_filter(11'd0, 11'd5);
    send_request(FUNC_INSERT, 64'h5555_aaaa_5555_aaaa);
    send_request(FUNC_PROBE, 64'h5555_aaaa_5555_aaaa);
    set_filter(11'd2047, 11'd31);
    send_request(FUNC_INSERT, 64'haaaa_5555_aaaa_5555);
    send_request(FUNC_PROBE, 64'haaaa_5555_aaaa_5555);
    set_filter(11'd4, 11'd0);
    send_request(FUNC_INSERT, 64'd77);
    send_request(FUNC_PROBE, 64'd77);

    run_phase(11'd1024, 11'd30, 30);
    run_phase(11'd2, 11'd3, 120);
    run_phase(11'd0, 11'd4, 60);
    run_phase(11'd2047, 11'd2, 120);
    run_phase(11'd3, 11'd0, 40);
    run_phase(11'd1, 11'd31, 30);
    while (sent < 1850) begin
      run_phase(11'($urandom_range(40)), 11'($urandom_range(1, 8)),
                (1850 - sent < 200) ? 1850 - sent : 200);
    end

    drain_results();
    repeat (100) @(negedge clk);
    $display("Covered %0d requests, %0d results, %0d probe hits, over sizes 0 to 2047 words.",
             sent, filter_sb.results, filter_sb.hits);
    $display("Probe counts from 0 to 31 were used, with clears and the unused operation code.");
    if (filter_sb.errors == 0 && filter_sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("TB_ERROR");
    $finish;
  end
endmodule
